// ===== src/crp_pkg.sv =====
// Package: shared types and constants for the cell reference parser.
package crp_pkg;

  localparam int unsigned MaxLettersDef = 3;
  localparam int unsigned MaxDigitsDef  = 17;

  localparam int unsigned CharW   = 8;
  localparam int unsigned LimitW  = 15;
  localparam int unsigned AccW    = 15;
  localparam int unsigned CoordW  = 14;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [AccW-1:0] NumCap    = 15'd16384;
  localparam logic [AccW-1:0] ColSat    = 15'd16385;
  localparam logic [CharW-1:0] LetterBase = 8'd64;
  localparam logic [CharW-1:0] DigitBase  = 8'h30;

  typedef enum logic [CfgIdxW-1:0] {
    CfgColumnLimit = 1'b0,
    CfgRowLimit    = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PhStart   = 2'd0,
    PhLetters = 2'd1,
    PhDigits  = 2'd2,
    PhError   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last_char;
  } in_item_t;

  typedef struct packed {
    logic              valid_res;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
  } out_item_t;

endpackage

// ===== src/cell_reference_parser_core.sv =====
// Top level: A1-style cell reference parser, one character per transaction.
//
// Characters enter one per transaction on the in channel; the transaction
// flagged last_char yields one result transaction (valid flag, zero-based
// column and row, zeros when the reference is rejected). One character per
// cycle is sustained unless a final character meets a stalled output: each
// sits in an input register while a constant multiply-add updates the column
// or row accumulator, and a final result is captured in an output register.
// The parse state is reset after every final character. Limits are to be
// written through the cfg port while the block is idle; this is not enforced.
module cell_reference_parser_core #(
  parameter int unsigned MaxLetters = crp_pkg::MaxLettersDef,
  parameter int unsigned MaxDigits  = crp_pkg::MaxDigitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [crp_pkg::LimitW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  crp_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output crp_pkg::out_item_t            out_data_o
);

  localparam int unsigned LetCntW = $clog2(MaxLetters + 1);
  localparam int unsigned DigCntW = $clog2(MaxDigits + 1);
  localparam logic [LetCntW-1:0] MaxLettersC = LetCntW'(MaxLetters);
  localparam logic [DigCntW-1:0] MaxDigitsC  = DigCntW'(MaxDigits);

  logic [crp_pkg::LimitW-1:0] col_limit_q, row_limit_q;

  logic              in_vld_q;
  crp_pkg::in_item_t in_item_q;
  logic              out_vld_q;
  crp_pkg::out_item_t out_item_q, out_item_d;

  crp_pkg::phase_e           phase_q, phase_d;
  logic [LetCntW-1:0]        let_cnt_q, let_cnt_d;
  logic [DigCntW-1:0]        dig_cnt_q, dig_cnt_d;
  logic [crp_pkg::AccW-1:0]  col_q, col_d;
  logic [crp_pkg::AccW-1:0]  row_q, row_d;
  logic                      too_big_q, too_big_d;

  logic                      adv, in_accept;
  logic                      is_letter, is_digit;
  logic [crp_pkg::CharW-1:0] ch;
  logic [18:0]               col_v;
  logic [17:0]               row_v;
  logic [crp_pkg::CharW-1:0] let_val, dig_val;
  logic [crp_pkg::AccW-1:0]  col_lim, row_lim;
  logic                      ok;

  assign adv        = in_vld_q && (!in_item_q.last_char || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign ch        = in_item_q.character;
  assign is_letter = (ch >= 8'h41) && (ch <= 8'h5A);
  assign is_digit  = (ch >= 8'h30) && (ch <= 8'h39);
  assign let_val   = ch - crp_pkg::LetterBase;
  assign dig_val   = ch - crp_pkg::DigitBase;

  // acc * 26 and acc * 10 as shift-add
  assign col_v = ({4'd0, col_q} << 4) + ({4'd0, col_q} << 3) + ({4'd0, col_q} << 1)
               + {11'd0, let_val};
  assign row_v = ({3'd0, row_q} << 3) + ({3'd0, row_q} << 1) + {10'd0, dig_val};

  // next parse state
  always_comb begin
    phase_d   = phase_q;
    let_cnt_d = let_cnt_q;
    dig_cnt_d = dig_cnt_q;
    col_d     = col_q;
    row_d     = row_q;
    too_big_d = too_big_q;
    if (phase_q != crp_pkg::PhError) begin
      if (is_letter) begin
        if (phase_q == crp_pkg::PhDigits || let_cnt_q >= MaxLettersC) begin
          phase_d = crp_pkg::PhError;
        end else begin
          col_d     = (col_v > 19'd16384) ? crp_pkg::ColSat : col_v[crp_pkg::AccW-1:0];
          let_cnt_d = let_cnt_q + 1'b1;
          phase_d   = crp_pkg::PhLetters;
        end
      end else if (is_digit) begin
        if (phase_q == crp_pkg::PhStart || dig_cnt_q >= MaxDigitsC ||
            (phase_q == crp_pkg::PhLetters && dig_val == '0)) begin
          phase_d = crp_pkg::PhError;
        end else begin
          if (too_big_q || row_v > 18'd16384) begin
            too_big_d = 1'b1;
          end else begin
            row_d = row_v[crp_pkg::AccW-1:0];
          end
          dig_cnt_d = dig_cnt_q + 1'b1;
          phase_d   = crp_pkg::PhDigits;
        end
      end else begin
        phase_d = crp_pkg::PhError;
      end
    end
  end

  // result of a final character
  always_comb begin
    col_lim = (col_limit_q > crp_pkg::NumCap) ? crp_pkg::NumCap : col_limit_q;
    row_lim = (row_limit_q > crp_pkg::NumCap) ? crp_pkg::NumCap : row_limit_q;
    ok = (phase_d == crp_pkg::PhDigits) && !too_big_d &&
         (col_d != '0) && (row_d != '0) && (col_d <= col_lim) && (row_d <= row_lim);
    out_item_d.valid_res = ok;
    out_item_d.column    = '0;
    out_item_d.row       = '0;
    if (ok) begin
      out_item_d.column = col_d[crp_pkg::CoordW-1:0] - 1'b1;
      out_item_d.row    = row_d[crp_pkg::CoordW-1:0] - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_limit_q <= crp_pkg::NumCap;
      row_limit_q <= crp_pkg::NumCap;
    end else if (cfg_we_i) begin
      case (crp_pkg::cfg_reg_e'(cfg_idx_i))
        crp_pkg::CfgColumnLimit: col_limit_q <= cfg_data_i;
        crp_pkg::CfgRowLimit:    row_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= crp_pkg::PhStart;
      let_cnt_q <= '0;
      dig_cnt_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
      too_big_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv && in_item_q.last_char) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (adv) begin
        if (in_item_q.last_char) begin
          phase_q   <= crp_pkg::PhStart;
          let_cnt_q <= '0;
          dig_cnt_q <= '0;
          col_q     <= '0;
          row_q     <= '0;
          too_big_q <= 1'b0;
        end else begin
          phase_q   <= phase_d;
          let_cnt_q <= let_cnt_d;
          dig_cnt_q <= dig_cnt_d;
          col_q     <= col_d;
          row_q     <= row_d;
          too_big_q <= too_big_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_data_i;
    end
    if (adv && in_item_q.last_char) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_item_q;

endmodule

// ===== src/crp_checker.sv =====
// Checker: port-level assertions for the cell reference parser, bound to the top level.
module crp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input crp_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input crp_pkg::out_item_t out_data_o
);

  // a stalled input transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input changed while stalled");

  // a stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // rejected reference reports zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |-> out_data_o.column == '0 && out_data_o.row == '0)
    else $error("invalid result with nonzero coordinates");

  // input backpressure only comes from a full, stalled result slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result slot can drain");

  // a new result appears only after an input transaction was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(!in_stall_o))
    else $error("result without pending input");

endmodule

bind cell_reference_parser_core crp_checker u_crp_checker (.*);

// ===== dv/testbench.sv =====
// Testbench for the cell reference parser: directed table, random references, checked by a predictor.
module testbench;
  import crp_pkg::*;

  localparam int NumPhases = 8;
  localparam int CharsPerPhase = 100;
  localparam int NumDirected = 23;

  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic              last;
    logic              typed;
    logic              valid;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } cell_row_t;

  // expected result typed in only on rows whose outcome is obvious
  localparam cell_row_t Directed[NumDirected] = '{
    '{"A", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"1", 1'b1, 1'b1, 1'b1, 14'd0, 14'd0},
    '{"X", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"F", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"D", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"1", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"6", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"3", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"8", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"4", 1'b1, 1'b1, 1'b1, 14'd16383, 14'd16383},
    '{"0", 1'b1, 1'b1, 1'b0, 14'd0, 14'd0},
    '{"A", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"0", 1'b1, 1'b1, 1'b0, 14'd0, 14'd0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 14'd0, 14'd0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 14'd0, 14'd0},
    '{"Z", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"Z", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"Z", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"1", 1'b1, 1'b1, 1'b0, 14'd0, 14'd0},
    '{"A", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"1", 1'b0, 1'b0, 1'b0, 14'd0, 14'd0},
    '{"B", 1'b1, 1'b1, 1'b0, 14'd0, 14'd0},
    '{"A", 1'b1, 1'b1, 1'b0, 14'd0, 14'd0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = CfgColumnLimit;
  logic [LimitW-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;

  cell_reference_parser_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #6000000;
    $display("testbench NOT OK");
    $finish;
  end

  // parser shadow state
  phase_e ps_phase = PhStart;
  int     ps_letters = 0;
  int     ps_col = 0;
  int     ps_digits = 0;
  int     ps_row = 0;
  bit     ps_row_big = 1'b0;
  int     lim_col = int'(NumCap);
  int     lim_row = int'(NumCap);

  out_item_t cell_results[$];
  logic [CharW-1:0] cell_text[$];
  int  errors = 0;
  bit  quiet = 1'b0;
  bit  stall_on = 1'b0;
  int  stall_run = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit parse_char(input in_item_t it, output out_item_t res);
    int v;
    int climit;
    int rlimit;
    int ch;
    ch = int'(it.character);
    res = '0;
    if (ps_phase != PhError) begin
      if (ch > int'(LetterBase) && ch <= int'(LetterBase) + 26) begin
        if (ps_phase == PhDigits || ps_letters >= int'(MaxLettersDef)) begin
          ps_phase = PhError;
        end else begin
          v = ps_col * 26 + (ch - int'(LetterBase));
          ps_col = (v > int'(NumCap)) ? int'(ColSat) : v;
          ps_letters++;
          ps_phase = PhLetters;
        end
      end else if (ch >= int'(DigitBase) && ch <= int'(DigitBase) + 9) begin
        if (ps_phase == PhStart || ps_digits >= int'(MaxDigitsDef) ||
            (ps_phase == PhLetters && ch == int'(DigitBase))) begin
          ps_phase = PhError;
        end else begin
          v = ps_row * 10 + (ch - int'(DigitBase));
          if (ps_row_big || v > int'(NumCap)) ps_row_big = 1'b1;
          else ps_row = v;
          ps_digits++;
          ps_phase = PhDigits;
        end
      end else begin
        ps_phase = PhError;
      end
    end
    if (!it.last_char) return 1'b0;
    climit = (lim_col > int'(NumCap)) ? int'(NumCap) : lim_col;
    rlimit = (lim_row > int'(NumCap)) ? int'(NumCap) : lim_row;
    if (ps_phase == PhDigits && !ps_row_big && ps_col >= 1 && ps_row >= 1 &&
        ps_col - 1 < climit && ps_row - 1 < rlimit) begin
      res.valid_res = 1'b1;
      res.column = CoordW'(ps_col - 1);
      res.row = CoordW'(ps_row - 1);
    end
    ps_phase = PhStart;
    ps_letters = 0;
    ps_col = 0;
    ps_digits = 0;
    ps_row = 0;
    ps_row_big = 1'b0;
    return 1'b1;
  endfunction

  task automatic drive_char(input in_item_t it, input bit typed = 1'b0,
                            input out_item_t want = '0);
    int gap;
    out_item_t res;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (parse_char(it, res)) cell_results = {cell_results, typed ? want : res};
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (cell_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [LimitW-1:0] col, input logic [LimitW-1:0] row);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgColumnLimit;
    cfg_data_i <= col;
    @(posedge clk_i);
    cfg_idx_i <= CfgRowLimit;
    cfg_data_i <= row;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim_col = int'(col);
    lim_row = int'(row);
  endtask

  // mostly well-formed references, some broken ones and some raw noise
  task automatic build_cell_text();
    int kind;
    int nl;
    int nd;
    int r;
    cell_text.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      repeat ($urandom_range(1, 6)) cell_text = {cell_text, CharW'($urandom_range(0, 255))};
      return;
    end
    r = $urandom_range(0, 19);
    nl = (r == 0) ? int'(MaxLettersDef) + 1 : (r < 9) ? 1 : (r < 16) ? 2 : 3;
    r = $urandom_range(0, 19);
    nd = (r == 0) ? int'(MaxDigitsDef) + 1 :
         (r == 1) ? $urandom_range(6, MaxDigitsDef) : $urandom_range(1, 5);
    repeat (nl) cell_text = {cell_text, LetterBase + CharW'($urandom_range(1, 26))};
    cell_text = {cell_text, DigitBase + CharW'($urandom_range(1, 9))};
    repeat (nd - 1) cell_text = {cell_text, DigitBase + CharW'($urandom_range(0, 9))};
    if (kind >= 70) begin
      case ($urandom_range(0, 4))
        0: cell_text[$urandom_range(0, cell_text.size() - 1)] = CharW'($urandom_range(0, 255));
        1: cell_text[nl] = DigitBase;
        2: while (cell_text.size() > nl) void'(cell_text.pop_back());
        3: repeat (nl) void'(cell_text.pop_front());
        default: cell_text = {cell_text, LetterBase + CharW'($urandom_range(1, 26))};
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_on = !stall_on && !quiet;
      stall_run = pick_gap();
    end
    out_stall_i <= stall_on;
  end

  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cell_results.size() == 0) begin
        $error("unexpected result transaction: %p", out_data_o);
        errors++;
      end else begin
        exp_res = cell_results.pop_front();
        if (out_data_o.valid_res !== exp_res.valid_res) begin
          $error("valid_res: expected %0d, got %0d", exp_res.valid_res, out_data_o.valid_res);
          errors++;
        end
        if (out_data_o.column !== exp_res.column) begin
          $error("column: expected %0d, got %0d", exp_res.column, out_data_o.column);
          errors++;
        end
        if (out_data_o.row !== exp_res.row) begin
          $error("row: expected %0d, got %0d", exp_res.row, out_data_o.row);
          errors++;
        end
      end
    end
  end

  initial begin
    int chars;
    logic [LimitW-1:0] col_lims[NumPhases];
    logic [LimitW-1:0] row_lims[NumPhases];
    col_lims = '{15'd1, 15'd0, 15'd702, 15'd26, 15'h7FFF, 15'd16384, 15'd16383, 15'd0};
    row_lims = '{15'd1, 15'd500, 15'd0, 15'd100, 15'h7FFF, 15'd16385, 15'd9999, 15'd0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumDirected; i++) begin
      drive_char('{character: Directed[i].ch, last_char: Directed[i].last},
                 Directed[i].typed,
                 '{valid_res: Directed[i].valid, column: Directed[i].col, row: Directed[i].row});
    end
    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      if (p == NumPhases - 1) begin
        col_lims[p] = LimitW'($urandom_range(1, 16384));
        row_lims[p] = LimitW'($urandom_range(1, 16384));
      end
      set_limits(col_lims[p], row_lims[p]);
      quiet = (p == 1 || p == 4);
      chars = 0;
      while (chars < CharsPerPhase) begin
        build_cell_text();
        foreach (cell_text[k]) begin
          drive_char('{character: cell_text[k], last_char: (k == cell_text.size() - 1)});
        end
        chars += cell_text.size();
      end
    end
    drain_results();
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/crp_pkg.sv
src/cell_reference_parser_core.sv
src/crp_checker.sv
dv/testbench.sv
